### hdl/mpu_cp_pkg.sv
// shared types, constants and functions of the protection-unit coprocessor
`default_nettype none
package mpu_cp_pkg;

   localparam int NUM_REGIONS = 8;
   localparam int RGN_IDX_W = 3;

   localparam logic [31:0] ID_CODE       = 32'd1090884705;
   localparam logic [31:0] CACHE_TYPE    = 32'd252518674;
   localparam logic [31:0] TCM_SIZE_INFO = 32'd1311104;

   localparam logic [31:0] CR_MASK   = 32'h000F_F085;
   localparam logic [31:0] DTCM_MASK = 32'hFFFF_F03E;
   localparam logic [31:0] ITCM_MASK = 32'h0000_003E;
   localparam logic [31:0] RGN_MASK  = 32'hFFFF_F03F;
   localparam logic [5:0]  MIN_SHIFT = 6'd12;
   localparam logic [5:0]  MAX_RSHIFT = 6'd32;
   localparam logic [5:0]  TCM_ADD = 6'd9;

   localparam int REQ_W = 56;
   localparam int RSP_W = 144;

   // kind of access held in the item register
   typedef enum logic [3:0] {
      K_NONE,
      K_READ,
      K_CTRL,
      K_DTCM,
      K_ITCM,
      K_PERM,
      K_REGION,
      K_WFI,
      K_PID
   } kind_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic finish;
      logic upd_dtcm;
      logic upd_itcm;
      logic upd_perms;
      logic upd_size_all;
      logic upd_size_one;
      logic force_last;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     mpu_on;
   } status_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] mask;
   } rgn_type;

   // window size as log2: size field plus nine, at least twelve
   function automatic logic [5:0] win_shift(input logic [31:0] r);
      logic [5:0] s;
      s = {1'b0, r[5:1]} + TCM_ADD;
      return (s < MIN_SHIFT) ? MIN_SHIFT : s;
   endfunction

   // region base and mask from the region register
   function automatic rgn_type region_size(input logic [31:0] raw);
      rgn_type    o;
      logic [5:0] s;
      s = {1'b0, raw[5:1]} + 6'd1;
      if (s < MIN_SHIFT) s = MIN_SHIFT;
      if (!raw[0]) begin
         o.base = 32'hFFFF_FFFF;
         o.mask = '0;
      end else if (s >= MAX_RSHIFT) begin
         o.base = '0;
         o.mask = '0;
      end else begin
         o.mask = 32'hFFFF_FFFF << s[4:0];
         o.base = raw & o.mask;
      end
      return o;
   endfunction

   // bits 0-2 privileged, 3-5 user, 6-8 cache attributes
   function automatic logic [8:0] perm_attrs(input logic [3:0] d, input logic [3:0] i,
                                             input logic ic, input logic dc,
                                             input logic bf);
      logic [2:0] pr;
      logic [2:0] us;
      pr = '0;
      us = '0;
      unique case (d)
         4'd1: pr = 3'd3;
         4'd2: begin pr = 3'd3; us = 3'd1; end
         4'd3: begin pr = 3'd3; us = 3'd3; end
         4'd5: pr = 3'd1;
         4'd6: begin pr = 3'd1; us = 3'd1; end
         default: ;
      endcase
      if (i == 4'd1 || i == 4'd5) begin
         pr[2] = 1'b1;
      end else if (i == 4'd2 || i == 4'd3 || i == 4'd6) begin
         pr[2] = 1'b1;
         us[2] = 1'b1;
      end
      return {bf, dc, ic, us, pr};
   endfunction

   // nibble low bits to packed 2-bit fields
   function automatic logic [31:0] legacy_pack(input logic [31:0] v);
      logic [31:0] o;
      o = '0;
      for (int k = 0; k < 8; k++) o[k*2 +: 2] = v[k*4 +: 2];
      return o;
   endfunction

   function automatic logic [31:0] legacy_unpack(input logic [31:0] v);
      logic [31:0] o;
      o = '0;
      for (int k = 0; k < 8; k++) o[k*4 +: 2] = v[k*2 +: 2];
      return o;
   endfunction

endpackage
`default_nettype wire

### hdl/mpu_cp_ctrl.sv
// sequencer: capture, commit and derive steps, result word handshake
`default_nettype none
module mpu_cp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire mpu_cp_pkg::status_type status,
   output mpu_cp_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_DERIVE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_ok;
   logic      accept;
   logic      is_ctrl;

   // output register free or emptied this cycle
   assign load_ok    = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_DERIVE) && load_ok);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign is_ctrl    = (status.kind == mpu_cp_pkg::K_CTRL);

   // commands
   always_comb begin
      cmd              = '0;
      cmd.capture      = accept;
      cmd.commit       = (state_ff == ST_EXEC);
      cmd.finish       = (state_ff == ST_DERIVE) && load_ok;
      if (cmd.finish) begin
         cmd.upd_dtcm     = is_ctrl || (status.kind == mpu_cp_pkg::K_DTCM);
         cmd.upd_itcm     = is_ctrl || (status.kind == mpu_cp_pkg::K_ITCM);
         cmd.upd_perms    = status.mpu_on &&
                            (is_ctrl || (status.kind == mpu_cp_pkg::K_PERM));
         cmd.upd_size_all = status.mpu_on && is_ctrl;
         cmd.upd_size_one = status.mpu_on && (status.kind == mpu_cp_pkg::K_REGION);
         cmd.force_last   = !status.mpu_on && is_ctrl;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_DERIVE;
         ST_DERIVE: begin
            if (load_ok) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### hdl/mpu_cp_dp.sv
// register file, region and window derivation, read mux, result register
`default_nettype none
module mpu_cp_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [mpu_cp_pkg::REQ_W-1:0] req_tdata,
   input  wire mpu_cp_pkg::cmd_type         cmd,
   output mpu_cp_pkg::status_type           status,
   output logic [mpu_cp_pkg::RSP_W-1:0]     rsp_tdata
);

   localparam int N = mpu_cp_pkg::NUM_REGIONS;

   // captured word
   logic        op_ff;
   logic [2:0]  opc1_ff;
   logic [3:0]  crn_ff;
   logic [3:0]  crm_ff;
   logic [2:0]  opc2_ff;
   logic [31:0] wdata_ff;
   logic [2:0]  sel_ff;

   // architectural registers
   logic [31:0] control_ff, control_in;
   logic [31:0] dtcm_ctrl_ff, itcm_ctrl_ff;
   logic [7:0]  dcache_ff, icache_ff, buffer_ff;
   logic [31:0] dperm_ff, iperm_ff, pid_ff;
   logic [31:0] rgn_ctrl_ff [N];

   // derived state
   logic [31:0] dbase_ff [N];
   logic [31:0] dbase_in [N];
   logic [31:0] dmask_ff [N];
   logic [31:0] dmask_in [N];
   logic [8:0]  dattr_ff [N];
   logic [8:0]  dattr_in [N];
   logic [19:0] tcm_base_ff, tcm_base_in;
   logic [5:0]  tcm_shift_ff, tcm_shift_in;
   logic        tcm_wr_ff, tcm_wr_in;
   logic        tcm_rd_ff, tcm_rd_in;
   logic [5:0]  itcm_shift_ff, itcm_shift_in;

   logic [mpu_cp_pkg::RSP_W-1:0] rsp_ff;

   mpu_cp_pkg::kind_type kind;
   logic [mpu_cp_pkg::RGN_IDX_W-1:0] rgn_idx;
   logic [31:0] rd_data;
   logic [5:0]  dshift;
   logic [31:0] dsh_val;
   mpu_cp_pkg::rgn_type rsz [N];

   assign rgn_idx = crm_ff[2:0];

   // access decode
   always_comb begin
      kind = mpu_cp_pkg::K_NONE;
      if (op_ff) begin
         kind = mpu_cp_pkg::K_READ;
      end else if (opc1_ff == 3'd0) begin
         priority if (crn_ff == 4'd1 && crm_ff == 4'd0 && opc2_ff == 3'd0)
            kind = mpu_cp_pkg::K_CTRL;
         else if (crn_ff == 4'd9 && crm_ff == 4'd1 && opc2_ff == 3'd0)
            kind = mpu_cp_pkg::K_DTCM;
         else if (crn_ff == 4'd9 && crm_ff == 4'd1 && opc2_ff == 3'd1)
            kind = mpu_cp_pkg::K_ITCM;
         else if (crn_ff == 4'd2 && crm_ff == 4'd0 && opc2_ff <= 3'd1)
            kind = mpu_cp_pkg::K_PERM;
         else if (crn_ff == 4'd3 && crm_ff == 4'd0 && opc2_ff == 3'd0)
            kind = mpu_cp_pkg::K_PERM;
         else if (crn_ff == 4'd5 && crm_ff == 4'd0 && opc2_ff <= 3'd3)
            kind = mpu_cp_pkg::K_PERM;
         else if (crn_ff == 4'd6 && opc2_ff == 3'd0 && !crm_ff[3])
            kind = mpu_cp_pkg::K_REGION;
         else if ((crn_ff == 4'd7 && crm_ff == 4'd0 && opc2_ff == 3'd4) ||
                  (crn_ff == 4'd15 && crm_ff == 4'd8 && opc2_ff == 3'd2))
            kind = mpu_cp_pkg::K_WFI;
         else if (crn_ff == 4'd13 && crm_ff <= 4'd1 && opc2_ff == 3'd1)
            kind = mpu_cp_pkg::K_PID;
         else
            kind = mpu_cp_pkg::K_NONE;
      end
   end

   assign status.kind   = kind;
   assign status.mpu_on = control_ff[0];

   // read mux
   always_comb begin
      rd_data = '0;
      if (opc1_ff == 3'd0) begin
         priority if (crn_ff == 4'd0 && crm_ff == 4'd0) begin
            rd_data = (opc2_ff == 3'd1) ? mpu_cp_pkg::CACHE_TYPE :
                      (opc2_ff == 3'd2) ? mpu_cp_pkg::TCM_SIZE_INFO : mpu_cp_pkg::ID_CODE;
         end else if (crn_ff == 4'd1 && crm_ff == 4'd0 && opc2_ff == 3'd0) begin
            rd_data = control_ff;
         end else if (crn_ff == 4'd2 && crm_ff == 4'd0 && opc2_ff == 3'd0) begin
            rd_data = {24'd0, dcache_ff};
         end else if (crn_ff == 4'd2 && crm_ff == 4'd0 && opc2_ff == 3'd1) begin
            rd_data = {24'd0, icache_ff};
         end else if (crn_ff == 4'd3 && crm_ff == 4'd0 && opc2_ff == 3'd0) begin
            rd_data = {24'd0, buffer_ff};
         end else if (crn_ff == 4'd5 && crm_ff == 4'd0) begin
            unique case (opc2_ff)
               3'd0:    rd_data = mpu_cp_pkg::legacy_pack(dperm_ff);
               3'd1:    rd_data = mpu_cp_pkg::legacy_pack(iperm_ff);
               3'd2:    rd_data = dperm_ff;
               3'd3:    rd_data = iperm_ff;
               default: rd_data = '0;
            endcase
         end else if (crn_ff == 4'd6 && opc2_ff <= 3'd1 && !crm_ff[3]) begin
            rd_data = rgn_ctrl_ff[rgn_idx];
         end else if (crn_ff == 4'd9 && crm_ff == 4'd1 && opc2_ff == 3'd0) begin
            rd_data = dtcm_ctrl_ff;
         end else if (crn_ff == 4'd9 && crm_ff == 4'd1 && opc2_ff == 3'd1) begin
            rd_data = itcm_ctrl_ff;
         end else if (crn_ff == 4'd13 && crm_ff <= 4'd1 && opc2_ff == 3'd1) begin
            rd_data = pid_ff;
         end else begin
            rd_data = '0;
         end
      end
   end

   // region size for every region in parallel
   always_comb begin
      for (int r = 0; r < N; r++) rsz[r] = mpu_cp_pkg::region_size(rgn_ctrl_ff[r]);
   end

   // derived region state
   always_comb begin
      for (int r = 0; r < N; r++) begin
         dbase_in[r] = dbase_ff[r];
         dmask_in[r] = dmask_ff[r];
         dattr_in[r] = dattr_ff[r];
         if (cmd.upd_perms) begin
            dattr_in[r] = mpu_cp_pkg::perm_attrs(dperm_ff[r*4 +: 4], iperm_ff[r*4 +: 4],
                                                control_ff[12] && icache_ff[r],
                                                control_ff[2] && dcache_ff[r],
                                                buffer_ff[r]);
         end
         if (cmd.upd_size_all || (cmd.upd_size_one && rgn_idx == r[2:0])) begin
            dbase_in[r] = rsz[r].base;
            dmask_in[r] = rsz[r].mask;
         end
      end
      if (cmd.force_last) begin
         dattr_in[N-1] = 9'h03F;
         dbase_in[N-1] = '0;
         dmask_in[N-1] = '0;
      end
   end

   // data and instruction windows
   assign dshift  = mpu_cp_pkg::win_shift(dtcm_ctrl_ff);
   assign dsh_val = dtcm_ctrl_ff >> dshift[4:0];
   always_comb begin
      tcm_base_in   = tcm_base_ff;
      tcm_shift_in  = tcm_shift_ff;
      tcm_wr_in     = tcm_wr_ff;
      tcm_rd_in     = tcm_rd_ff;
      itcm_shift_in = itcm_shift_ff;
      if (cmd.upd_dtcm) begin
         tcm_base_in = '0;
         tcm_wr_in   = 1'b0;
         tcm_rd_in   = 1'b0;
         if (control_ff[16]) begin
            tcm_shift_in = dshift;
            tcm_base_in  = (dshift >= 6'd32) ? 20'd0 : dsh_val[19:0];
            tcm_wr_in    = 1'b1;
            tcm_rd_in    = !control_ff[17];
         end
      end
      if (cmd.upd_itcm) itcm_shift_in = mpu_cp_pkg::win_shift(itcm_ctrl_ff);
   end

   assign control_in = (control_ff & ~mpu_cp_pkg::CR_MASK) | (wdata_ff & mpu_cp_pkg::CR_MASK);

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tdata[0];
         opc1_ff  <= req_tdata[3:1];
         crn_ff   <= req_tdata[7:4];
         crm_ff   <= req_tdata[11:8];
         opc2_ff  <= req_tdata[14:12];
         wdata_ff <= req_tdata[46:15];
         sel_ff   <= req_tdata[49:47];
      end
   end

   // register writes and derived state
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff    <= '0;
         dtcm_ctrl_ff  <= '0;
         itcm_ctrl_ff  <= '0;
         dcache_ff     <= '0;
         icache_ff     <= '0;
         buffer_ff     <= '0;
         dperm_ff      <= '0;
         iperm_ff      <= '0;
         pid_ff        <= '0;
         tcm_base_ff   <= '0;
         tcm_shift_ff  <= mpu_cp_pkg::MIN_SHIFT;
         tcm_wr_ff     <= 1'b0;
         tcm_rd_ff     <= 1'b0;
         itcm_shift_ff <= mpu_cp_pkg::MIN_SHIFT;
         for (int r = 0; r < N; r++) begin
            rgn_ctrl_ff[r] <= '0;
            dbase_ff[r]    <= '0;
            dmask_ff[r]    <= '0;
            dattr_ff[r]    <= '0;
         end
      end else begin
         if (cmd.commit) begin
            unique case (kind)
               mpu_cp_pkg::K_CTRL: control_ff   <= control_in;
               mpu_cp_pkg::K_DTCM: dtcm_ctrl_ff <= wdata_ff & mpu_cp_pkg::DTCM_MASK;
               mpu_cp_pkg::K_ITCM: itcm_ctrl_ff <= wdata_ff & mpu_cp_pkg::ITCM_MASK;
               mpu_cp_pkg::K_PERM: begin
                  if (crn_ff == 4'd2 && opc2_ff == 3'd0) dcache_ff <= wdata_ff[7:0];
                  if (crn_ff == 4'd2 && opc2_ff == 3'd1) icache_ff <= wdata_ff[7:0];
                  if (crn_ff == 4'd3) buffer_ff <= wdata_ff[7:0];
                  if (crn_ff == 4'd5) begin
                     unique case (opc2_ff[1:0])
                        2'd0: dperm_ff <= mpu_cp_pkg::legacy_unpack(wdata_ff);
                        2'd1: iperm_ff <= mpu_cp_pkg::legacy_unpack(wdata_ff);
                        2'd2: dperm_ff <= wdata_ff;
                        default: iperm_ff <= wdata_ff;
                     endcase
                  end
               end
               mpu_cp_pkg::K_REGION: rgn_ctrl_ff[rgn_idx] <= wdata_ff & mpu_cp_pkg::RGN_MASK;
               mpu_cp_pkg::K_PID:    pid_ff <= wdata_ff;
               default: ;
            endcase
         end
         tcm_base_ff   <= tcm_base_in;
         tcm_shift_ff  <= tcm_shift_in;
         tcm_wr_ff     <= tcm_wr_in;
         tcm_rd_ff     <= tcm_rd_in;
         itcm_shift_ff <= itcm_shift_in;
         for (int r = 0; r < N; r++) begin
            dbase_ff[r] <= dbase_in[r];
            dmask_ff[r] <= dmask_in[r];
            dattr_ff[r] <= dattr_in[r];
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= {4'd0, itcm_shift_in, tcm_shift_in, tcm_base_in, tcm_wr_in, tcm_rd_in,
                    dattr_in[sel_ff][8:6], dattr_in[sel_ff][5:3], dattr_in[sel_ff][2:0],
                    dmask_in[sel_ff], dbase_in[sel_ff],
                    (kind == mpu_cp_pkg::K_WFI),
                    op_ff ? rd_data : 32'd0};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule
`default_nettype wire

### hdl/mpu_control_coprocessor.sv
// top level of the protection-unit system-control coprocessor
//
// channel | dir | word
// req_*   | in  | one coprocessor register access
// rsp_*   | out | read data, wait request, selected region and window state
//
// each word is captured, committed in the exec step, then derived and its result loaded in the derive step.
// derivation of all eight regions runs in parallel in the derive cycle.
// a new word is taken in idle, or in the derive cycle when the result register is free or being emptied.
// reset is synchronous; it clears the architectural and derived registers to zero and window shifts to twelve.
// a stalled result holds the sequencer in the derive step.
`default_nettype none
module mpu_control_coprocessor (
   input  wire logic         clock,
   input  wire logic         reset,
   // op, opc1, crn, crm, opc2, write_data, region_sel
   input  wire logic [55:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // read_data, wait_request, region_base, region_mask, priv_perm, user_perm,
   // region_cache_attr, dtcm_read_enable, dtcm_write_enable, dtcm_base,
   // dtcm_shift, itcm_shift
   output logic [143:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);

   mpu_cp_pkg::cmd_type    cmd;
   mpu_cp_pkg::status_type status;

   mpu_cp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mpu_cp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

### hdl/mpu_cp_checker.sv
// port-level checks of the coprocessor
`default_nettype none
module mpu_cp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic [55:0]  req_tdata,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [143:0] rsp_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one word at a time
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted during commit");

   // result register loaded in the derive step that follows the commit, or an older result still waits
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##3 rsp_tvalid)
      else $error("result missing");

   // wait request only on writes, which return no data
   a_wfi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("wait request with read data");

   // read window implies write window
   a_tcm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[106] |-> rsp_tdata[107])
      else $error("data window read enable without write enable");

endmodule

bind mpu_control_coprocessor mpu_cp_checker u_checker (.*);
`default_nettype wire

### test/tb.sv
// self-checking testbench of the protection-unit coprocessor register file
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // access fields as they sit in req_tdata
   typedef struct packed {
      logic [2:0]  region_sel;
      logic [31:0] write_data;
      logic [2:0]  opc2;
      logic [3:0]  crm;
      logic [3:0]  crn;
      logic [2:0]  opc1;
      logic        op;
   } access_type;

   // result fields, lowest first from the bottom of the struct
   typedef struct packed {
      logic [5:0]  itcm_shift;
      logic [5:0]  dtcm_shift;
      logic [19:0] dtcm_base;
      logic        dtcm_write_enable;
      logic        dtcm_read_enable;
      logic [2:0]  region_cache_attr;
      logic [2:0]  user_perm;
      logic [2:0]  priv_perm;
      logic [31:0] region_mask;
      logic [31:0] region_base;
      logic        wait_request;
      logic [31:0] read_data;
   } status_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [55:0]   req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;

   mpu_control_coprocessor dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the register file
   logic [31:0] m_ctrl, m_dtcm, m_itcm, m_dc, m_ic, m_bf, m_dperm, m_iperm, m_pid;
   logic [31:0] m_rgn[8], m_base[8], m_mask[8];
   logic [8:0]  m_attr[8];
   logic [19:0] m_wbase;
   logic [5:0]  m_dshift, m_ishift;
   logic        m_wr, m_rd;

   status_type expected_q[$];
   int errors = 0;
   int n_reads = 0, n_writes = 0, n_wfi = 0;

   function automatic logic [5:0] size_log2(logic [31:0] r);
      logic [5:0] s;
      s = 6'(r[5:1]) + 6'd9;
      return s < 6'd12 ? 6'd12 : s;
   endfunction

   task automatic reset_model();
      m_ctrl = 0; m_dtcm = 0; m_itcm = 0; m_dc = 0; m_ic = 0; m_bf = 0;
      m_dperm = 0; m_iperm = 0; m_pid = 0;
      for (int r = 0; r < 8; r++) begin
         m_rgn[r] = 0; m_base[r] = 0; m_mask[r] = 0; m_attr[r] = 0;
      end
      m_wbase = 0; m_dshift = 12; m_ishift = 12; m_wr = 0; m_rd = 0;
   endtask

   task automatic derive_window();
      m_wbase = 0; m_wr = 0; m_rd = 0;
      if (m_ctrl[16]) begin
         m_dshift = size_log2(m_dtcm);
         m_wbase = m_dshift >= 32 ? 20'd0 : 20'(m_dtcm >> m_dshift);
         m_wr = 1'b1;
         m_rd = !m_ctrl[17];
      end
   endtask

   task automatic derive_region(int r);
      int sz;
      if (!m_ctrl[0]) return;
      if (!m_rgn[r][0]) begin
         m_mask[r] = 0; m_base[r] = '1;
         return;
      end
      sz = m_rgn[r][5:1] + 1;
      if (sz < 12) sz = 12;
      if (sz >= 32) begin
         m_mask[r] = 0; m_base[r] = 0;
      end else begin
         m_mask[r] = 32'hFFFF_FFFF << sz;
         m_base[r] = m_rgn[r] & m_mask[r];
      end
   endtask

   task automatic derive_perms();
      logic [3:0] d, i;
      logic [2:0] pr, us, ca;
      if (!m_ctrl[0]) return;
      for (int r = 0; r < 8; r++) begin
         d = m_dperm[r*4 +: 4]; i = m_iperm[r*4 +: 4];
         pr = 0; us = 0; ca = 0;
         case (d)
            1: pr = 3;
            2: begin pr = 3; us = 1; end
            3: begin pr = 3; us = 3; end
            5: pr = 1;
            6: begin pr = 1; us = 1; end
            default: ;
         endcase
         if (i == 1 || i == 5) pr[2] = 1;
         else if (i == 2 || i == 3 || i == 6) begin pr[2] = 1; us[2] = 1; end
         ca[0] = m_ctrl[12] & m_ic[r];
         ca[1] = m_ctrl[2] & m_dc[r];
         ca[2] = m_bf[r];
         m_attr[r] = {ca, us, pr};
      end
   endtask

   function automatic logic [31:0] nibbles_to_pairs(logic [31:0] v);
      logic [31:0] o = 0;
      for (int k = 0; k < 8; k++) o[k*2 +: 2] = v[k*4 +: 2];
      return o;
   endfunction

   function automatic logic [31:0] pairs_to_nibbles(logic [31:0] v);
      logic [31:0] o = 0;
      for (int k = 0; k < 8; k++) o[k*4 +: 2] = v[k*2 +: 2];
      return o;
   endfunction

   // apply one access to the shadow and return the status word it should give
   task automatic predict_access(input access_type a, output status_type s);
      logic [2:0] o2;
      logic [3:0] n, m;
      logic [31:0] v;
      s = '0;
      n = a.crn; m = a.crm; o2 = a.opc2; v = a.write_data;
      if (a.op == OP_READ) begin
         n_reads++;
         if (a.opc1 == 0) begin
            if (n == 0 && m == 0)
               s.read_data = o2 == 1 ? mpu_cp_pkg::CACHE_TYPE :
                             o2 == 2 ? mpu_cp_pkg::TCM_SIZE_INFO : mpu_cp_pkg::ID_CODE;
            else if (n == 1 && m == 0 && o2 == 0) s.read_data = m_ctrl;
            else if (n == 2 && m == 0 && o2 == 0) s.read_data = m_dc;
            else if (n == 2 && m == 0 && o2 == 1) s.read_data = m_ic;
            else if (n == 3 && m == 0 && o2 == 0) s.read_data = m_bf;
            else if (n == 5 && m == 0)
               s.read_data = o2 == 0 ? nibbles_to_pairs(m_dperm) :
                             o2 == 1 ? nibbles_to_pairs(m_iperm) :
                             o2 == 2 ? m_dperm : o2 == 3 ? m_iperm : 32'd0;
            else if (n == 6 && o2 <= 1 && m < 8) s.read_data = m_rgn[m[2:0]];
            else if (n == 9 && m == 1 && o2 == 0) s.read_data = m_dtcm;
            else if (n == 9 && m == 1 && o2 == 1) s.read_data = m_itcm;
            else if (n == 13 && m <= 1 && o2 == 1) s.read_data = m_pid;
         end
      end else begin
         n_writes++;
         if (a.opc1 == 0) begin
            if (n == 1 && m == 0 && o2 == 0) begin
               m_ctrl = (m_ctrl & ~mpu_cp_pkg::CR_MASK) | (v & mpu_cp_pkg::CR_MASK);
               derive_window();
               m_ishift = size_log2(m_itcm);
               if (m_ctrl[0]) begin
                  derive_perms();
                  for (int r = 0; r < 8; r++) derive_region(r);
               end else begin
                  m_attr[7] = 9'o077; m_base[7] = 0; m_mask[7] = 0;
               end
            end else if (n == 9 && m == 1 && o2 == 0) begin
               m_dtcm = v & mpu_cp_pkg::DTCM_MASK; derive_window();
            end else if (n == 9 && m == 1 && o2 == 1) begin
               m_itcm = v & mpu_cp_pkg::ITCM_MASK; m_ishift = size_log2(m_itcm);
            end else if (n == 2 && m == 0 && o2 == 0) begin
               m_dc = v & 32'hFF; derive_perms();
            end else if (n == 2 && m == 0 && o2 == 1) begin
               m_ic = v & 32'hFF; derive_perms();
            end else if (n == 3 && m == 0 && o2 == 0) begin
               m_bf = v & 32'hFF; derive_perms();
            end else if (n == 5 && m == 0 && o2 <= 3) begin
               case (o2)
                  0: m_dperm = pairs_to_nibbles(v);
                  1: m_iperm = pairs_to_nibbles(v);
                  2: m_dperm = v;
                  default: m_iperm = v;
               endcase
               derive_perms();
            end else if (n == 6 && o2 == 0 && m < 8) begin
               m_rgn[m[2:0]] = v & mpu_cp_pkg::RGN_MASK; derive_region(m[2:0]);
            end else if ((n == 7 && m == 0 && o2 == 4) || (n == 15 && m == 8 && o2 == 2)) begin
               s.wait_request = 1; n_wfi++;
            end else if (n == 13 && m <= 1 && o2 == 1) begin
               m_pid = v;
            end
         end
      end
      s.region_base = m_base[a.region_sel];
      s.region_mask = m_mask[a.region_sel];
      {s.region_cache_attr, s.user_perm, s.priv_perm} = m_attr[a.region_sel];
      s.dtcm_read_enable = m_rd;
      s.dtcm_write_enable = m_wr;
      s.dtcm_base = m_wr ? m_wbase : 20'd0;
      s.dtcm_shift = m_dshift;
      s.itcm_shift = m_ishift;
   endtask

   // result checker
   always @(posedge clock) begin
      status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[139:0];
         if (expected_q.size() == 0) begin
            $error("result word with none expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               errors++;
               if (got.read_data !== want.read_data)
                  $error("read_data exp %h got %h", want.read_data, got.read_data);
               if (got.wait_request !== want.wait_request)
                  $error("wait_request exp %b got %b", want.wait_request, got.wait_request);
               if (got.region_base !== want.region_base)
                  $error("region_base exp %h got %h", want.region_base, got.region_base);
               if (got.region_mask !== want.region_mask)
                  $error("region_mask exp %h got %h", want.region_mask, got.region_mask);
               if (got.priv_perm !== want.priv_perm)
                  $error("priv_perm exp %h got %h", want.priv_perm, got.priv_perm);
               if (got.user_perm !== want.user_perm)
                  $error("user_perm exp %h got %h", want.user_perm, got.user_perm);
               if (got.region_cache_attr !== want.region_cache_attr)
                  $error("region_cache_attr exp %h got %h",
                         want.region_cache_attr, got.region_cache_attr);
               if (got.dtcm_read_enable !== want.dtcm_read_enable)
                  $error("dtcm_read_enable exp %b got %b",
                         want.dtcm_read_enable, got.dtcm_read_enable);
               if (got.dtcm_write_enable !== want.dtcm_write_enable)
                  $error("dtcm_write_enable exp %b got %b",
                         want.dtcm_write_enable, got.dtcm_write_enable);
               if (got.dtcm_base !== want.dtcm_base)
                  $error("dtcm_base exp %h got %h", want.dtcm_base, got.dtcm_base);
               if (got.dtcm_shift !== want.dtcm_shift)
                  $error("dtcm_shift exp %0d got %0d", want.dtcm_shift, got.dtcm_shift);
               if (got.itcm_shift !== want.itcm_shift)
                  $error("itcm_shift exp %0d got %0d", want.itcm_shift, got.itcm_shift);
            end
         end
      end
   end

   // receiver stall pattern: long open stretches and stall bursts
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (phase < 60) ? 1'b1 : (phase < 80 ? rsp_tready : 1'b0);
   end

   // directed table: access plus an optional typed-in read value
   typedef struct {
      access_type  a;
      logic        has_val;
      logic [31:0] val;
   } row_type;
   row_type dir_rows[$];

   function automatic access_type mk(logic op, logic [2:0] o1, logic [3:0] n, logic [3:0] m,
                                     logic [2:0] o2, logic [31:0] v, logic [2:0] sel);
      access_type a;
      a.op = op; a.opc1 = o1; a.crn = n; a.crm = m; a.opc2 = o2;
      a.write_data = v; a.region_sel = sel;
      return a;
   endfunction

   task automatic add_row(access_type a, logic hv = 0, logic [31:0] v = 0);
      row_type r;
      r.a = a; r.has_val = hv; r.val = v;
      dir_rows.push_back(r);
   endtask

   // predict and queue its result, drive one word, then wait for acceptance
   task automatic send_word(input access_type a);
      status_type s;
      predict_access(a, s);
      expected_q.push_back(s);
      req_tdata <= {6'd0, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drop_valid(int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a random coprocessor access, mostly to mapped registers
   function automatic access_type rand_access();
      access_type a;
      int pick;
      a = mk(1'($urandom_range(0, 1)), 3'd0, 4'd0, 4'd0, 3'd0, $urandom,
             3'($urandom_range(0, 7)));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         a.opc1 = 3'($urandom); a.crn = 4'($urandom);
         a.crm = 4'($urandom); a.opc2 = 3'($urandom);
      end else if (pick < 22) begin
         a.crn = 4'd1;
         a.write_data = $urandom | ($urandom_range(0, 3) != 0 ? 32'h1 : 32'h0);
      end else if (pick < 30) begin
         a.crn = 4'($urandom_range(2, 3)); a.opc2 = 3'($urandom_range(0, 1));
      end else if (pick < 42) begin
         a.crn = 4'd5; a.opc2 = 3'($urandom_range(0, 4));
      end else if (pick < 65) begin
         a.crn = 4'd6; a.crm = 4'($urandom_range(0, 9)); a.opc2 = 3'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) a.write_data[5:1] = 5'($urandom_range(28, 31));
      end else if (pick < 80) begin
         a.crn = 4'd9; a.crm = 4'd1; a.opc2 = 3'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) a.write_data[5:1] = 5'($urandom_range(22, 31));
      end else if (pick < 86) begin
         a.crn = 4'd13; a.crm = 4'($urandom_range(0, 2)); a.opc2 = 3'd1;
      end else if (pick < 91) begin
         if ($urandom_range(0, 1) != 0) begin a.crn = 4'd7; a.opc2 = 3'd4; end
         else begin a.crn = 4'd15; a.crm = 4'd8; a.opc2 = 3'd2; end
      end else begin
         a.opc2 = 3'($urandom);
      end
      return a;
   endfunction

   initial begin
      int idx, burst, wait_cycles;
      logic paused;
      paused = 1'b0;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: id registers, reset values, extremes and special cases
      add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 1, mpu_cp_pkg::ID_CODE);
      add_row(mk(OP_READ, 0, 0, 0, 1, 0, 7), 1, mpu_cp_pkg::CACHE_TYPE);
      add_row(mk(OP_READ, 0, 0, 0, 2, 0, 0), 1, mpu_cp_pkg::TCM_SIZE_INFO);
      add_row(mk(OP_READ, 0, 0, 0, 7, 0, 0), 1, mpu_cp_pkg::ID_CODE);
      add_row(mk(OP_READ, 7, 0, 0, 0, 0, 0), 1, 32'd0);
      add_row(mk(OP_READ, 0, 1, 0, 0, 0, 0), 1, 32'd0);
      add_row(mk(OP_WRITE, 0, 1, 0, 0, 32'h0, 7));
      add_row(mk(OP_WRITE, 0, 6, 0, 0, 32'hFFFF_FFFF, 0));
      add_row(mk(OP_WRITE, 0, 6, 7, 0, 32'h0000_0001, 7));
      add_row(mk(OP_WRITE, 0, 6, 8, 0, 32'h1234_5679, 0));
      add_row(mk(OP_WRITE, 0, 5, 0, 0, 32'hFFFF_FFFF, 1));
      add_row(mk(OP_WRITE, 0, 5, 0, 3, 32'h6532_1076, 2));
      add_row(mk(OP_WRITE, 0, 2, 0, 0, 32'hFFFF_FFFF, 3));
      add_row(mk(OP_WRITE, 0, 3, 0, 0, 32'h0000_00A5, 4));
      add_row(mk(OP_WRITE, 0, 1, 0, 0, 32'hFFFF_FFFF, 0));
      add_row(mk(OP_READ, 0, 1, 0, 0, 0, 1), 1, mpu_cp_pkg::CR_MASK);
      add_row(mk(OP_WRITE, 0, 9, 1, 0, 32'hFFFF_FFFF, 5));
      add_row(mk(OP_WRITE, 0, 9, 1, 1, 32'h0000_0000, 6));
      add_row(mk(OP_READ, 0, 5, 0, 0, 0, 0), 1, 32'h0000_FFFF);
      add_row(mk(OP_WRITE, 0, 6, 3, 0, 32'h8000_0015, 3));
      add_row(mk(OP_WRITE, 0, 6, 2, 0, 32'h0000_0000, 2));
      add_row(mk(OP_WRITE, 0, 7, 0, 4, 0, 0));
      add_row(mk(OP_WRITE, 0, 15, 8, 2, 0, 0));
      add_row(mk(OP_WRITE, 0, 13, 1, 1, 32'hDEAD_BEEF, 0));
      add_row(mk(OP_READ, 0, 13, 0, 1, 0, 0), 1, 32'hDEAD_BEEF);

      // typed-in values are checked here against the predictor's shadow
      foreach (dir_rows[k]) begin
         send_word(dir_rows[k].a);
         if (dir_rows[k].has_val && expected_q[$].read_data !== dir_rows[k].val) begin
            $error("read_data exp %h got %h", dir_rows[k].val, expected_q[$].read_data);
            errors++;
         end
         drop_valid($urandom_range(0, 2));
      end

      // hold off until every result is back
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);

      // random bursts with random gaps
      idx = 0;
      while (idx < 1700) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && idx < 1700; b++, idx++) send_word(rand_access());
         drop_valid($urandom_range(0, 1) != 0 ? $urandom_range(1, 6) : 0);
         if (!paused && idx >= 900) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_q.size() != 0) errors++;

      $display("covered %0d reads, %0d writes, %0d wait requests", n_reads, n_writes, n_wfi);
      if (errors == 0) $display("mpu_control_coprocessor verification clean");
      else $display("mpu_control_coprocessor verification failed");
      $finish;
   end

   // run-time limit
   initial begin
      #5_000_000;
      $display("mpu_control_coprocessor verification failed");
      $finish;
   end
endmodule
`default_nettype wire
